[hw/rtl/two_stage_soil_evaporation_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the two-stage soil evaporation unit
// Implication and next-cycle checks on clk with synchronous rst_n.
// ---------------------------------------------------------------------------
`ifndef TWO_STAGE_SOIL_EVAPORATION_UNIT_ASSERT_SVH
`define TWO_STAGE_SOIL_EVAPORATION_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSE_ASSERT_IMP(lbl, ante, cons, msg)
`define TSE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/tse_pkg.sv]
// ---------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the two-stage soil evaporation unit.
// ---------------------------------------------------------------------------
package tse_pkg;

  localparam int unsigned DATA_W = 31;
  localparam int unsigned REG_W  = 2;
  localparam int unsigned STEPS  = 24;   // bits handled by each serial unit
  localparam int unsigned CNT_W  = 5;

  localparam logic [DATA_W-1:0] TIME_MAX    = 31'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_ONE       = 31'd65536;
  localparam logic [15:0]       Q_POINT_SIX = 16'd39322;
  localparam logic [DATA_W-1:0] LIMIT_RESET = 31'd393216;
  localparam logic [DATA_W-1:0] COEFF_RESET = 31'd229376;

  localparam logic [REG_W-1:0] REG_STAGE1_LIMIT = 2'd0;
  localparam logic [REG_W-1:0] REG_STAGE2_COEFF = 2'd1;

  typedef struct packed {
    logic [DATA_W-1:0] infiltration;
    logic [DATA_W-1:0] potential_evap;
    logic [DATA_W-1:0] evap_cap;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] actual_evap;
    logic              second_stage;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[hw/rtl/two_stage_soil_evaporation_unit.sv]
// ---------------------------------------------------------------------------
// two_stage_soil_evaporation_unit
// Daily two-stage bare-soil evaporation in signed Q16.16 fixed point.
// ---------------------------------------------------------------------------
// Each input transaction is one day (infiltration, potential evaporation,
// evaporable-water cap); each gives exactly one output transaction with the
// clamped actual evaporation and a flag that is set when stage one was
// already exhausted. The unit keeps the cumulative stage-one and stage-two
// totals and the stage-two time, all cleared by reset; the stage-one limit
// and stage-two coefficient are written through the cfg_ port (index 0 and
// 1, other indexes ignored); the user must write them only while the unit
// is idle, which the unit itself does not enforce. One day is worked at a
// time: after a result is ready the unit passes through its done state back
// to idle before the next day is accepted. The work is done by three
// bit-serial units: a divider and a multiplier that turn the stage-two total
// back into time ((total/coeff)^2), and a square root followed by the
// multiplier for the stage-two bound coeff*sqrt(t+1). A day with
// infiltration and an open stage one that needs the bound costs the most
// (two time recomputations plus root and bound). Every day with stage one
// still open recomputes the time after the update; the divider and the
// multiplier are skipped only when the stage-two total is so large against
// the coefficient that the time saturates. A dry day handled in stage two
// only runs the root and the bound. A finished result waits in an output
// register, so the next day is accepted while the previous result has not
// yet been taken.
// ---------------------------------------------------------------------------
`include "two_stage_soil_evaporation_unit_assert.svh"

module two_stage_soil_evaporation_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tse_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tse_pkg::out_t                       out_data,
  input  logic                                cfg_wen,
  input  logic [tse_pkg::REG_W-1:0]           cfg_index,
  input  logic [tse_pkg::DATA_W-1:0]          cfg_wdata
);

  localparam int unsigned W = tse_pkg::DATA_W;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_INF    = 11'b000_0000_0010,
    ST_TCHK   = 11'b000_0000_0100,
    ST_TDIV   = 11'b000_0000_1000,
    ST_TSQR   = 11'b000_0001_0000,
    ST_DECIDE = 11'b000_0010_0000,
    ST_ROOT   = 11'b000_0100_0000,
    ST_BMUL   = 11'b000_1000_0000,
    ST_FMUL   = 11'b001_0000_0000,
    ST_UPDATE = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] res;
    if ((v[41:31] == 11'h000) || (v[41:31] == 11'h7FF)) begin
      res = v[31:0];
    end else begin
      res = v[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

  state_t state_r, state_nxt;

  logic [W-1:0]        limit_r, coeff_r;
  logic signed [31:0]  s1_r, s2_r;
  logic [W-1:0]        time_r;
  logic [W-1:0]        inf_r, pot_r, cap_r;
  logic                flag_r;
  logic                tail_r;
  logic [W-1:0]        e1_r;
  logic signed [40:0]  e2_r;
  logic [W-1:0]        act_r;
  logic                out_valid_r;
  tse_pkg::out_t       out_data_r;

  // serial units
  tse_pkg::unit_stat_t         div_stat, sqrt_stat, mul_stat;
  logic                        div_start, sqrt_start, mul_start;
  logic [tse_pkg::STEPS-1:0]   div_quot, sqrt_root, mul_b;
  logic [W-1:0]                mul_a;
  logic [55:0]                 mul_prod;

  // combinational datapath
  logic [W-1:0]        coeff_nz;
  logic signed [33:0]  d_raw;
  logic signed [34:0]  s2_m;
  logic signed [32:0]  s1_m;
  logic signed [31:0]  s1_inf, s2_inf;
  logic [31:0]         s2_abs;
  logic                t_ovf;
  logic [W-1:0]        t_sq;
  logic signed [32:0]  room;
  logic                stage1_open;
  logic [W-1:0]        e1_calc;
  logic                cond;
  logic                need_root;
  logic [31:0]         time_inc;
  logic [W-1:0]        time_stepped;
  logic [38:0]         bound;
  logic signed [40:0]  bound_diff, pot_left, e2_bound;
  logic signed [40:0]  lim, e2f;
  logic signed [41:0]  s1_sum, s2_sum, act_sum;
  logic [W-1:0]        act_lo, act_fin;
  logic                out_free;

  assign coeff_nz = (coeff_r == '0) ? W'(1) : coeff_r;

  // Infiltration: lower both totals, never below zero.
  assign d_raw  = $signed({3'b000, inf_r}) - $signed({{2{s1_r[31]}}, s1_r});
  assign s2_m   = $signed({{3{s2_r[31]}}, s2_r}) - (d_raw[33] ? 35'sd0 : {d_raw[33], d_raw});
  assign s2_inf = s2_m[34] ? 32'sd0 : s2_m[31:0];
  assign s1_m   = $signed({s1_r[31], s1_r}) - $signed({2'b00, inf_r});
  assign s1_inf = s1_m[32] ? 32'sd0 : s1_m[31:0];

  // Time from total: screen quotients of 2^24 and up before dividing.
  assign s2_abs = s2_r[31] ? (~s2_r + 32'd1) : s2_r;
  assign t_ovf  = {7'd0, s2_abs} >= {coeff_nz, 8'd0};
  assign t_sq   = mul_prod[47] ? tse_pkg::TIME_MAX : mul_prod[46:16];

  // Stage-one decision.
  assign room        = $signed({2'b00, limit_r}) - $signed({s1_r[31], s1_r});
  assign stage1_open = room > 33'sd0;
  assign e1_calc     = !stage1_open ? '0 :
                       (room > $signed({2'b00, pot_r})) ? pot_r : room[W-1:0];
  assign cond        = (pot_r > e1_calc) && (e1_calc < cap_r);
  assign need_root   = !stage1_open || (cond && (s2_r > 32'sd0));

  // Advance the stage-two time by one day, saturating.
  assign time_inc     = {1'b0, time_r} + {1'b0, tse_pkg::Q_ONE};
  assign time_stepped = time_inc[31] ? tse_pkg::TIME_MAX : time_inc[W-1:0];

  // Stage-two bound minus the current total, against the remaining demand.
  assign bound      = mul_prod[54:16];
  assign bound_diff = $signed({2'b00, bound}) - $signed({{9{s2_r[31]}}, s2_r});
  assign pot_left   = $signed({10'd0, pot_r - e1_r});
  assign e2_bound   = (bound_diff < pot_left) ? bound_diff : pot_left;

  // Final update: clamp stage two to the cap left after stage one.
  assign lim     = $signed({10'd0, cap_r}) - $signed({10'd0, e1_r});
  assign e2f     = (e2_r < lim) ? e2_r : lim;
  assign s1_sum  = $signed({{10{s1_r[31]}}, s1_r}) + $signed({11'd0, e1_r});
  assign s2_sum  = $signed({{10{s2_r[31]}}, s2_r}) + $signed({e2f[40], e2f});
  assign act_sum = $signed({11'd0, e1_r}) + $signed({e2f[40], e2f});
  assign act_lo  = act_sum[41] ? '0 :
                   (act_sum > $signed({11'd0, pot_r})) ? pot_r : act_sum[W-1:0];
  assign act_fin = (act_lo > cap_r) ? cap_r : act_lo;

  assign out_free = !out_valid_r || out_ready;

  // Unit starts and the shared multiplier's operands.
  always_comb begin
    div_start  = (state_r == ST_TCHK) && !t_ovf;
    sqrt_start = (state_r == ST_DECIDE) && need_root;
    mul_start  = 1'b0;
    mul_a      = coeff_nz;
    mul_b      = sqrt_root;
    case (state_r)
      ST_TDIV: begin
        mul_start = div_stat.done;
        mul_a     = W'(div_quot);
        mul_b     = div_quot;
      end
      ST_ROOT: begin
        mul_start = sqrt_stat.done;
      end
      ST_DECIDE: begin
        mul_start = !need_root && cond;
        mul_a     = pot_r - e1_calc;
        mul_b     = tse_pkg::STEPS'(tse_pkg::Q_POINT_SIX);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_INF;
      ST_INF:    state_nxt = (inf_r != '0) ? ST_TCHK : ST_DECIDE;
      ST_TCHK: begin
        if (!t_ovf) begin
          state_nxt = ST_TDIV;
        end else begin
          state_nxt = tail_r ? ST_DONE : ST_DECIDE;
        end
      end
      ST_TDIV:   if (div_stat.done) state_nxt = ST_TSQR;
      ST_TSQR:   if (mul_stat.done) state_nxt = tail_r ? ST_DONE : ST_DECIDE;
      ST_DECIDE: begin
        if (need_root) begin
          state_nxt = ST_ROOT;
        end else if (cond) begin
          state_nxt = ST_FMUL;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_ROOT:   if (sqrt_stat.done) state_nxt = ST_BMUL;
      ST_BMUL:   if (mul_stat.done) state_nxt = ST_UPDATE;
      ST_FMUL:   if (mul_stat.done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = flag_r ? ST_DONE : ST_TCHK;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and the carried totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= tse_pkg::LIMIT_RESET;
      coeff_r     <= tse_pkg::COEFF_RESET;
      s1_r        <= '0;
      s2_r        <= '0;
      time_r      <= '0;
      tail_r      <= 1'b0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        case (cfg_index)
          tse_pkg::REG_STAGE1_LIMIT: limit_r <= cfg_wdata;
          tse_pkg::REG_STAGE2_COEFF: coeff_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_INF: begin
          tail_r <= 1'b0;
          if (inf_r != '0) begin
            s1_r <= s1_inf;
            s2_r <= s2_inf;
          end
        end
        ST_TCHK:   if (t_ovf) time_r <= tse_pkg::TIME_MAX;
        ST_TSQR:   if (mul_stat.done) time_r <= t_sq;
        ST_DECIDE: begin
          flag_r <= !stage1_open;
          if (need_root) time_r <= time_stepped;
        end
        ST_UPDATE: begin
          s2_r   <= sat32(s2_sum);
          tail_r <= 1'b1;
          if (!flag_r) s1_r <= sat32(s1_sum);
        end
        default: ;
      endcase
    end
  end

  // Day payload and working values.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      inf_r <= in_data.infiltration;
      pot_r <= in_data.potential_evap;
      cap_r <= in_data.evap_cap;
    end
    case (state_r)
      ST_DECIDE: begin
        e1_r <= e1_calc;
        e2_r <= '0;
      end
      ST_BMUL:   if (mul_stat.done) e2_r <= e2_bound;
      ST_FMUL:   if (mul_stat.done) e2_r <= $signed({10'd0, mul_prod[46:16]});
      ST_UPDATE: act_r <= act_fin;
      ST_DONE: begin
        if (out_free) begin
          out_data_r.actual_evap  <= act_r;
          out_data_r.second_stage <= flag_r;
        end
      end
      default: ;
    endcase
  end

  tse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (s2_abs),
    .den   (coeff_nz),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  tse_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (time_stepped),
    .stat  (sqrt_stat),
    .root  (sqrt_root)
  );

  tse_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One day at a time: ready drops after each accepted transaction.
  `TSE_ASSERT_NXT(a_one_day, in_valid && in_ready, !in_ready, "second day accepted early")
  // The multiplier and the divider are never restarted while busy.
  `TSE_ASSERT_IMP(a_mul_free, mul_start, !mul_stat.busy, "multiplier restarted while busy")
  `TSE_ASSERT_IMP(a_div_free, div_start, !div_stat.busy, "divider restarted while busy")
  // Stage-one total is never negative.
  `TSE_ASSERT_IMP(a_s1_pos, 1'b1, !s1_r[31], "stage-one total went negative")
  // A finished day lands in the output register.
  `TSE_ASSERT_NXT(a_out_load, (state_r == ST_DONE) && out_free, out_valid, "result lost")

endmodule

[hw/rtl/tse_div.sv]
// ---------------------------------------------------------------------------
// tse_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den, for
// quotients below 2^24 (the caller screens larger ones out).
// ---------------------------------------------------------------------------
module tse_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [31:0]                    num,
  input  logic [tse_pkg::DATA_W-1:0]     den,
  output tse_pkg::unit_stat_t            stat,
  output logic [tse_pkg::STEPS-1:0]      quot
);

  logic [tse_pkg::DATA_W-1:0] rem_r;
  logic [tse_pkg::DATA_W-1:0] den_r;
  logic [tse_pkg::STEPS-1:0]  dq_r;
  logic [tse_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [31:0]                trial;
  logic                       ge;

  assign trial = {rem_r, dq_r[tse_pkg::STEPS-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tse_pkg::CNT_W'(tse_pkg::STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= {7'd0, num[31:8]};
      dq_r  <= {num[7:0], 16'd0};
    end else if (busy_r) begin
      rem_r <= ge ? tse_pkg::DATA_W'(trial - {1'b0, den_r}) : trial[tse_pkg::DATA_W-1:0];
      dq_r  <= {dq_r[tse_pkg::STEPS-2:0], ge};
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign quot = dq_r;

endmodule

[hw/rtl/tse_sqrt.sv]
// ---------------------------------------------------------------------------
// tse_sqrt
// Digit-by-digit square root of (t << 16), one root bit per cycle.
// ---------------------------------------------------------------------------
module tse_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tse_pkg::DATA_W-1:0]     rad,
  output tse_pkg::unit_stat_t            stat,
  output logic [tse_pkg::STEPS-1:0]      root
);

  logic [47:0]                rad_r;
  logic [25:0]                rem_r;
  logic [tse_pkg::STEPS-1:0]  root_r;
  logic [tse_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [27:0]                rem2;
  logic [27:0]                trial;
  logic                       ge;

  assign rem2  = {rem_r, rad_r[47:46]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tse_pkg::CNT_W'(tse_pkg::STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {1'b0, rad, 16'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[45:0], 2'b00};
      rem_r  <= ge ? 26'(rem2 - trial) : rem2[25:0];
      root_r <= {root_r[tse_pkg::STEPS-2:0], ge};
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign root = root_r;

endmodule

[hw/rtl/tse_mul.sv]
// ---------------------------------------------------------------------------
// tse_mul
// Shift-and-add multiplier, one multiplier bit per cycle; a 32-bit adder.
// ---------------------------------------------------------------------------
module tse_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tse_pkg::DATA_W-1:0]     a,
  input  logic [tse_pkg::STEPS-1:0]      b,
  output tse_pkg::unit_stat_t            stat,
  output logic [55:0]                    prod
);

  logic [tse_pkg::DATA_W-1:0] a_r;
  logic [31:0]                hi_r;
  logic [tse_pkg::STEPS-1:0]  lo_r;
  logic [tse_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [32:0]                sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {2'b00, a_r} : 33'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tse_pkg::CNT_W'(tse_pkg::STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[32:1];
      lo_r <= {sum[0], lo_r[tse_pkg::STEPS-1:1]};
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign prod = {hi_r, lo_r};

endmodule

[tb/two_stage_soil_evaporation_unit_tb.sv]
// ---------------------------------------------------------------------------
// Testbench for the two-stage soil evaporation unit
// Feeds daily transactions through a valid/ready driver and checks every
// result in order against a cycle-free predictor of the unit's arithmetic.
// Stage-one limit and stage-two coefficient are changed between phases.
// ---------------------------------------------------------------------------
module two_stage_soil_evaporation_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int MAX_SHOWN      = 10;
  localparam int STALL_CYCLES   = 400;
  localparam logic [tse_pkg::REG_W-1:0] REG_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tse_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tse_pkg::out_t out_data;
  logic cfg_wen = 1'b0;
  logic [tse_pkg::REG_W-1:0] cfg_index = '0;
  logic [tse_pkg::DATA_W-1:0] cfg_wdata = '0;

  two_stage_soil_evaporation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state: a private copy of the soil water bookkeeping
  logic [30:0] limit_q, coeff_q;
  longint s1_tot, s2_tot, s2_days;

  tse_pkg::in_t  day_queue[$];
  tse_pkg::out_t evap_expected[$];
  int   mismatches = 0;
  int   days_sent = 0, results_seen = 0, stage2_days_seen = 0;
  bit   timed_out = 1'b0;
  bit   sender_quiet = 1'b1;      // hold the driver off
  bit   receiver_quiet = 1'b1;    // receiver idling disabled
  bit   stall_req = 1'b0;         // ask the receiver for one long stall
  bit   stall_taken = 1'b0;
  int   hold_off = 0;
  int   idle_pct = 25;
  int   quiet_cycles = 0;
  logic in_ready_seen = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint eff_coeff();
    return (coeff_q == 0) ? 64'd1 : longint'(coeff_q);
  endfunction

  function automatic longint days_from_total(longint tot);
    longint unsigned mag, quo, sq;
    mag = (tot < 0) ? -tot : tot;
    quo = (mag << 16) / eff_coeff();
    if (quo >= (64'd1 << 24)) return 64'sd2147483647;
    sq = (quo * quo) >> 16;
    if (sq > 64'd2147483647) return 64'sd2147483647;
    return sq;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint stage2_ceiling();
    longint unsigned t;
    t = (s2_days < 0) ? 0 : s2_days;
    return (eff_coeff() * int_root(t << 16)) >> 16;
  endfunction

  function automatic void advance_day();
    s2_days = s2_days + 65536;
    if (s2_days > 64'sd2147483647) s2_days = 64'sd2147483647;
  endfunction

  function automatic longint min_l(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  // Work out one day's evaporation and advance the bookkeeping
  function automatic tse_pkg::out_t evaporate_day(tse_pkg::in_t d);
    longint inf, pot, cap, e1, e2, act, a1, a2, deficit;
    tse_pkg::out_t r;
    inf = d.infiltration;
    pot = d.potential_evap;
    cap = d.evap_cap;
    if (inf > 0) begin
      a1 = s1_tot;
      a2 = s2_tot;
      deficit = inf - a1;
      if (deficit < 0) deficit = 0;
      a2 -= deficit;
      if (a2 < 0) a2 = 0;
      a1 -= inf;
      if (a1 < 0) a1 = 0;
      s1_tot = clamp32(a1);
      s2_tot = clamp32(a2);
      s2_days = days_from_total(s2_tot);
    end
    if (s1_tot < longint'(limit_q)) begin
      r.second_stage = 1'b0;
      e1 = min_l(pot, longint'(limit_q) - s1_tot);
      if (pot > e1 && e1 < cap) begin
        if (s2_tot > 0) begin
          advance_day();
          e2 = min_l(pot - e1, stage2_ceiling() - s2_tot);
        end else begin
          e2 = ((pot - e1) * 39322) >>> 16;
        end
      end else begin
        e2 = 0;
      end
      e2 = min_l(e2, cap - e1);
      s1_tot = clamp32(s1_tot + e1);
      s2_tot = clamp32(s2_tot + e2);
      s2_days = days_from_total(s2_tot);
    end else begin
      r.second_stage = 1'b1;
      e1 = 0;
      advance_day();
      e2 = min_l(min_l(pot, stage2_ceiling() - s2_tot), cap);
      s2_tot = clamp32(s2_tot + e2);
    end
    act = e1 + e2;
    if (act < 0) act = 0;
    if (act > pot) act = pot;
    if (act > cap) act = cap;
    r.actual_evap = act[30:0];
    return r;
  endfunction

  // Driver: advance at the falling edge, hold valid and payload until taken
  always @(negedge clk) begin
    if (!in_valid || in_ready_seen) begin
      if (!sender_quiet && day_queue.size() != 0 &&
          (idle_pct == 0 || $urandom_range(99) >= idle_pct)) begin
        in_data  <= day_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random idling, plus one long stall counted here
  always @(negedge clk) begin
    if (stall_req && !stall_taken) begin
      stall_taken <= 1'b1;
      hold_off    <= STALL_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else begin
      out_ready <= receiver_quiet ? 1'b1 : ($urandom_range(99) >= idle_pct);
    end
  end

  // Sample the input handshake at the rising edge for the driver's use
  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready && rst_n;
  end

  // Monitor: predict on accepted days, check on accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        evap_expected.push_back(evaporate_day(in_data));
        days_sent++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.second_stage) stage2_days_seen++;
        if (evap_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("ERROR: unexpected result evap=%0d flag=%0b",
                     out_data.actual_evap, out_data.second_stage);
        end else begin
          tse_pkg::out_t want;
          want = evap_expected.pop_front();
          if (want.actual_evap !== out_data.actual_evap ||
              want.second_stage !== out_data.second_stage) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("ERROR: result %0d expected evap=%0d flag=%0b got evap=%0d flag=%0b",
                       results_seen, want.actual_evap, want.second_stage,
                       out_data.actual_evap, out_data.second_stage);
          end
        end
      end
      // Watchdog: count cycles with no transaction while work is pending
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (evap_expected.size() == 0 && !in_valid))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [tse_pkg::REG_W-1:0] idx,
                           logic [tse_pkg::DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx == tse_pkg::REG_STAGE1_LIMIT) limit_q = val;
    else if (idx == tse_pkg::REG_STAGE2_COEFF) coeff_q = val;
  endtask

  // Wait until all queued days have gone in and every result has come out
  task automatic drain();
    sender_quiet = 1'b0;
    while (day_queue.size() != 0 || in_valid) @(posedge clk);
    sender_quiet = 1'b1;
    while (evap_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [30:0] rand_field();
    case ($urandom_range(5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(65535));
      3: return 31'($urandom_range(20 * 65536));
      4: return 31'($urandom_range(2 * 65536));
      default: return 31'($urandom() & 32'h7FFF_FFFF);
    endcase
  endfunction

  function automatic tse_pkg::in_t dry_spell_day();
    tse_pkg::in_t d;
    // Mostly realistic weather; now and then a wet day or a wild value
    d.infiltration   = ($urandom_range(9) == 0) ? 31'($urandom_range(30 * 65536))
                                                : 31'd0;
    d.potential_evap = 31'($urandom_range(12 * 65536));
    d.evap_cap       = ($urandom_range(3) == 0) ? 31'($urandom_range(8 * 65536))
                                                : 31'($urandom_range(40 * 65536));
    if ($urandom_range(19) == 0) begin
      d.infiltration   = rand_field();
      d.potential_evap = rand_field();
      d.evap_cap       = rand_field();
    end
    return d;
  endfunction

  task automatic queue_days(int n);
    repeat (n) day_queue.push_back(dry_spell_day());
  endtask

  initial begin
    tse_pkg::in_t d;
    limit_q = tse_pkg::LIMIT_RESET;
    coeff_q = tse_pkg::COEFF_RESET;
    s1_tot = 0; s2_tot = 0; s2_days = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, wet days, dry run into stage two, caps
    d = '{31'd0, 31'd0, 31'd0};                     day_queue.push_back(d);
    d = '{31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF};     day_queue.push_back(d);
    d = '{31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF};     day_queue.push_back(d);
    d = '{31'd0, 31'd5 << 16, 31'd1 << 16};         day_queue.push_back(d);
    d = '{31'h7FFF_FFFF, 31'd0, 31'd0};             day_queue.push_back(d);
    d = '{31'd0, 31'd8 << 16, 31'h7FFF_FFFF};       day_queue.push_back(d);
    repeat (6) begin
      d = '{31'd0, 31'd4 << 16, 31'd30 << 16};      day_queue.push_back(d);
    end
    d = '{31'd3 << 16, 31'd4 << 16, 31'd2 << 16};   day_queue.push_back(d);
    d = '{31'd0, 31'd7 << 16, 31'd6 << 16};         day_queue.push_back(d);
    d = '{31'd1, 31'd1, 31'd1};                     day_queue.push_back(d);
    d = '{31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555}; day_queue.push_back(d);
    d = '{31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA}; day_queue.push_back(d);
    drain();

    // Small coefficient and odd register writes
    write_reg(tse_pkg::REG_STAGE2_COEFF, 31'd65);
    write_reg(tse_pkg::REG_STAGE1_LIMIT, 31'd0);
    write_reg(REG_UNKNOWN, 31'h1234_5678);
    repeat (6) begin
      d = '{31'd0, 31'd3 << 16, 31'd10 << 16};      day_queue.push_back(d);
    end
    d = '{31'd2 << 16, 31'd3 << 16, 31'h7FFF_FFFF}; day_queue.push_back(d);
    drain();

    write_reg(tse_pkg::REG_STAGE1_LIMIT, 31'h7FFF_FFFF);
    write_reg(tse_pkg::REG_STAGE2_COEFF, 31'h7FFF_FFFF);
    d = '{31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF};     day_queue.push_back(d);
    d = '{31'd0, 31'h7FFF_FFFF, 31'd5};             day_queue.push_back(d);
    drain();

    // Random phases with varied configuration, idling enabled in all but one
    receiver_quiet = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(tse_pkg::REG_STAGE1_LIMIT, tse_pkg::LIMIT_RESET);
                 write_reg(tse_pkg::REG_STAGE2_COEFF, tse_pkg::COEFF_RESET); end
        1: begin write_reg(tse_pkg::REG_STAGE1_LIMIT, 31'($urandom_range(12 * 65536)));
                 write_reg(tse_pkg::REG_STAGE2_COEFF,
                           31'($urandom_range(65, 6 * 65536))); end
        2: begin write_reg(tse_pkg::REG_STAGE1_LIMIT, 31'd0);
                 write_reg(tse_pkg::REG_STAGE2_COEFF, 31'd65); end
        3: begin write_reg(tse_pkg::REG_STAGE1_LIMIT, 31'($urandom() & 32'h7FFF_FFFF));
                 write_reg(tse_pkg::REG_STAGE2_COEFF, 31'($urandom() & 32'h7FFF_FFFF)); end
        default: begin write_reg(tse_pkg::REG_STAGE1_LIMIT, 31'($urandom_range(9 * 65536)));
                 write_reg(tse_pkg::REG_STAGE2_COEFF,
                           31'($urandom_range(65536, 5 * 65536))); end
      endcase
      idle_pct = (phase == 2) ? 0 : 25;   // one stretch with no idling
      queue_days(190);
      if (phase == 1) begin
        // Long receiver stall while days keep arriving
        sender_quiet = 1'b0;
        @(negedge clk);
        stall_req = 1'b1;
      end
      drain();
    end

    $display("Run covered %0d days, %0d results, %0d handled in stage two only.",
             days_sent, results_seen, stage2_days_seen);
    if (mismatches == 0 && evap_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
